FILE: src/tcba_pkg.sv
// ----------------------------------------------------------------------------
// tcba_pkg
// Types, codes and constants shared by the three-class block allocator.
// ----------------------------------------------------------------------------
package tcba_pkg;

  // Default pool sizes, in blocks.
  localparam int SMALL_BLOCKS_DEFAULT  = 1024;
  localparam int MEDIUM_BLOCKS_DEFAULT = 512;
  localparam int LARGE_BLOCKS_DEFAULT  = 256;

  // Block sizes in bytes and the matching shifts.
  localparam int SMALL_BYTES  = 32;
  localparam int MEDIUM_BYTES = 64;
  localparam int LARGE_BYTES  = 128;
  localparam int SMALL_SHIFT  = 5;
  localparam int MEDIUM_SHIFT = 6;
  localparam int LARGE_SHIFT  = 7;

  // Reset values of the base registers.
  localparam logic [31:0] SMALL_BASE_RESET  = 32'd0;
  localparam logic [31:0] MEDIUM_BASE_RESET = 32'd32768;
  localparam logic [31:0] LARGE_BASE_RESET  = 32'd65536;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    CLASS_SMALL  = 2'd0,
    CLASS_MEDIUM = 2'd1,
    CLASS_LARGE  = 2'd2,
    CLASS_NONE   = 2'd3
  } size_class_t;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_EMPTY     = 3'd1,
    STAT_TOO_LARGE = 3'd2,
    STAT_NULL      = 3'd3,
    STAT_FOREIGN   = 3'd4,
    STAT_FULL      = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    REG_SMALL_BASE  = 2'd0,
    REG_MEDIUM_BASE = 2'd1,
    REG_LARGE_BASE  = 2'd2
  } reg_index_t;

  typedef struct packed {
    action_t     action;
    logic [31:0] request_size;
    logic [31:0] block_address;
  } req_t;

  typedef struct packed {
    logic [31:0] granted_address;
    size_class_t size_class;
    status_t     status;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // take the accepted request into the datapath
    logic decide;   // classify, check pools and update the stacks
    logic load;     // form the result and load the output register
  } dp_cmd_t;

endpackage

FILE: src/three_class_block_allocator.sv
// ----------------------------------------------------------------------------
// three_class_block_allocator
// Segregated free-list allocator for 32, 64 and 128 byte blocks.
// ----------------------------------------------------------------------------
// The allocator keeps one LIFO free stack of block indices for each of three
// pools (32-byte, 64-byte and 128-byte blocks), each pool starting at a base
// address held in a configuration register. After reset every pool is full
// and the highest index is handed out first. An allocate transfer picks the
// smallest class that fits request_size and returns base + index * size; a
// size above 128 bytes is reported as too large and an exhausted pool as
// empty. A free transfer ignores a null address, pushes the block of the
// first pool (small, then medium, then large) whose range holds the address,
// reports a full pool, and reports any other address as foreign. Each request
// yields exactly one result transfer. A request is first classified, when the
// stack is pushed or its RAM read is issued, and then finishes, when the
// popped index comes out of the RAM's registered read port and the address
// is formed; the next request is taken in that finishing step, so a new
// request is accepted while the previous one finishes. A stalled result
// holds the block in its finishing step. The stacks need no clearing pass
// after reset: a mark of the lowest fill count reached tells apart entries
// never written, which read as their own index. The user must write base
// registers through the plain write port only while no request is in
// flight; the block itself does not enforce this. Index 3 is ignored.
// ----------------------------------------------------------------------------
module three_class_block_allocator #(
  parameter int SMALL_BLOCKS  = tcba_pkg::SMALL_BLOCKS_DEFAULT,
  parameter int MEDIUM_BLOCKS = tcba_pkg::MEDIUM_BLOCKS_DEFAULT,
  parameter int LARGE_BLOCKS  = tcba_pkg::LARGE_BLOCKS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_write_en,
  input  logic [1:0]     cfg_index,
  input  logic [31:0]    cfg_wdata,
  input  logic           req_valid,
  output logic           req_ready,
  input  tcba_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output tcba_pkg::rsp_t rsp
);

  import tcba_pkg::*;

  // Command bundle from the sequencer to the datapath.
  dp_cmd_t cmd;

  // The sequencer owns both handshakes and steps each request through its
  // classify and finish cycles.
  tcba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd)
  );

  // The datapath holds the base registers, the request, the three pools and
  // the result register that parts the two sides.
  tcba_datapath #(
    .SMALL_BLOCKS  (SMALL_BLOCKS),
    .MEDIUM_BLOCKS (MEDIUM_BLOCKS),
    .LARGE_BLOCKS  (LARGE_BLOCKS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .cmd          (cmd),
    .req          (req),
    .rsp          (rsp)
  );

endmodule

FILE: src/tcba_ram.sv
// ----------------------------------------------------------------------------
// tcba_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tcba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/tcba_pool.sv
// ----------------------------------------------------------------------------
// tcba_pool
// One size class: LIFO free stack in RAM, fill count and membership test.
// ----------------------------------------------------------------------------
module tcba_pool #(
  parameter int BLOCKS = 256,
  parameter int SHIFT  = 7
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] base,
  input  logic [31:0] free_addr,
  input  logic        do_pop,
  input  logic        do_push,
  output logic        hit,
  output logic        empty,
  output logic        full,
  output logic [31:0] pop_offset
);

  localparam int CW = $clog2(BLOCKS + 1);
  localparam int IW = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
  localparam logic [32:0] SPAN = 33'(BLOCKS) << SHIFT;

  logic [CW-1:0] count;
  logic [CW-1:0] mark;      // lowest fill count reached since reset
  logic [CW-1:0] count_dec;
  logic          fresh;
  logic          fresh_q;
  logic [IW-1:0] fresh_idx_q;
  logic [IW-1:0] rd_data;
  logic [IW-1:0] pop_idx;
  logic [31:0]   off;
  logic [31:0]   off_shifted;

  assign off         = free_addr - base;
  assign off_shifted = off >> SHIFT;
  assign hit         = ({1'b0, off} < SPAN);
  assign empty       = (count == '0);
  assign full        = (count == CW'(BLOCKS));
  assign count_dec   = count - CW'(1);

  // An entry at or above the mark has been written since reset; one below
  // it still holds its own position, as after reset.
  assign fresh = (count == mark);

  tcba_ram #(
    .WIDTH (IW),
    .DEPTH (BLOCKS)
  ) u_stack (
    .clk   (clk),
    .we    (do_push),
    .waddr (count[IW-1:0]),
    .wdata (off_shifted[IW-1:0]),
    .re    (do_pop),
    .raddr (count_dec[IW-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= CW'(BLOCKS);
      mark    <= CW'(BLOCKS);
      fresh_q <= 1'b0;
    end else begin
      if (do_pop) begin
        count   <= count_dec;
        fresh_q <= fresh;
        if (fresh) begin
          mark <= count_dec;
        end
      end else if (do_push) begin
        count <= count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      fresh_idx_q <= count_dec[IW-1:0];
    end
  end

  assign pop_idx    = fresh_q ? fresh_idx_q : rd_data;
  assign pop_offset = 32'(pop_idx) << SHIFT;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(BLOCKS)) else $error("pool fill count above pool size");
  a_mark_below_count: assert property (@(posedge clk) disable iff (rst)
    mark <= count) else $error("pool mark above fill count");
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    !(do_pop && do_push)) else $error("pool pop and push together");
  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    do_pop |-> !empty) else $error("pop from an empty pool");
`endif

endmodule

FILE: src/tcba_datapath.sv
// ----------------------------------------------------------------------------
// tcba_datapath
// Base registers, request register, the three pools and the result register.
// ----------------------------------------------------------------------------
module tcba_datapath #(
  parameter int SMALL_BLOCKS  = 1024,
  parameter int MEDIUM_BLOCKS = 512,
  parameter int LARGE_BLOCKS  = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write_en,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_wdata,
  input  tcba_pkg::dp_cmd_t cmd,
  input  tcba_pkg::req_t    req,
  output tcba_pkg::rsp_t    rsp
);

  import tcba_pkg::*;

  logic [31:0] small_base;
  logic [31:0] medium_base;
  logic [31:0] large_base;

  req_t        req_q;
  size_class_t dec_cls;
  status_t     dec_status;
  logic        dec_pop;
  logic        dec_push;
  size_class_t res_cls;
  status_t     res_status;
  logic        res_pop;

  logic [2:0]  hit;
  logic [2:0]  empty;
  logic [2:0]  full;
  logic [2:0]  pop;
  logic [2:0]  push;
  logic [31:0] offset [3];
  logic [31:0] sel_base;
  logic [31:0] sel_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      small_base  <= SMALL_BASE_RESET;
      medium_base <= MEDIUM_BASE_RESET;
      large_base  <= LARGE_BASE_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_SMALL_BASE:  small_base  <= cfg_wdata;
        REG_MEDIUM_BASE: medium_base <= cfg_wdata;
        REG_LARGE_BASE:  large_base  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req;
    end
  end

  // Classification of the held request against the pools' present state.
  always_comb begin
    dec_cls    = CLASS_NONE;
    dec_status = STAT_OK;
    dec_pop    = 1'b0;
    dec_push   = 1'b0;
    if (req_q.action == ACT_ALLOC) begin
      if (req_q.request_size <= 32'(SMALL_BYTES)) begin
        dec_cls = CLASS_SMALL;
      end else if (req_q.request_size <= 32'(MEDIUM_BYTES)) begin
        dec_cls = CLASS_MEDIUM;
      end else if (req_q.request_size <= 32'(LARGE_BYTES)) begin
        dec_cls = CLASS_LARGE;
      end
      if (dec_cls == CLASS_NONE) begin
        dec_status = STAT_TOO_LARGE;
      end else if (empty[dec_cls]) begin
        dec_status = STAT_EMPTY;
      end else begin
        dec_pop = 1'b1;
      end
    end else begin
      if (req_q.block_address == '0) begin
        dec_status = STAT_NULL;
      end else begin
        if (hit[0]) begin
          dec_cls = CLASS_SMALL;
        end else if (hit[1]) begin
          dec_cls = CLASS_MEDIUM;
        end else if (hit[2]) begin
          dec_cls = CLASS_LARGE;
        end
        if (dec_cls == CLASS_NONE) begin
          dec_status = STAT_FOREIGN;
        end else if (full[dec_cls]) begin
          dec_status = STAT_FULL;
        end else begin
          dec_push = 1'b1;
        end
      end
    end
  end

  always_comb begin
    pop  = '0;
    push = '0;
    if (cmd.decide && dec_cls != CLASS_NONE) begin
      pop[dec_cls]  = dec_pop;
      push[dec_cls] = dec_push;
    end
  end

  tcba_pool #(.BLOCKS(SMALL_BLOCKS), .SHIFT(SMALL_SHIFT)) u_small (
    .clk        (clk),
    .rst        (rst),
    .base       (small_base),
    .free_addr  (req_q.block_address),
    .do_pop     (pop[0]),
    .do_push    (push[0]),
    .hit        (hit[0]),
    .empty      (empty[0]),
    .full       (full[0]),
    .pop_offset (offset[0])
  );

  tcba_pool #(.BLOCKS(MEDIUM_BLOCKS), .SHIFT(MEDIUM_SHIFT)) u_medium (
    .clk        (clk),
    .rst        (rst),
    .base       (medium_base),
    .free_addr  (req_q.block_address),
    .do_pop     (pop[1]),
    .do_push    (push[1]),
    .hit        (hit[1]),
    .empty      (empty[1]),
    .full       (full[1]),
    .pop_offset (offset[1])
  );

  tcba_pool #(.BLOCKS(LARGE_BLOCKS), .SHIFT(LARGE_SHIFT)) u_large (
    .clk        (clk),
    .rst        (rst),
    .base       (large_base),
    .free_addr  (req_q.block_address),
    .do_pop     (pop[2]),
    .do_push    (push[2]),
    .hit        (hit[2]),
    .empty      (empty[2]),
    .full       (full[2]),
    .pop_offset (offset[2])
  );

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      res_cls    <= dec_cls;
      res_status <= dec_status;
      res_pop    <= dec_pop;
    end
  end

  always_comb begin
    case (res_cls)
      CLASS_SMALL: begin
        sel_base   = small_base;
        sel_offset = offset[0];
      end
      CLASS_MEDIUM: begin
        sel_base   = medium_base;
        sel_offset = offset[1];
      end
      CLASS_LARGE: begin
        sel_base   = large_base;
        sel_offset = offset[2];
      end
      default: begin
        sel_base   = '0;
        sel_offset = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rsp.granted_address <= res_pop ? (sel_base + sel_offset) : '0;
      rsp.size_class      <= res_cls;
      rsp.status          <= res_status;
    end
  end

endmodule

FILE: src/tcba_ctrl.sv
// ----------------------------------------------------------------------------
// tcba_ctrl
// Sequencer: accept, decide, finish; owns the handshakes of both channels.
// ----------------------------------------------------------------------------
module tcba_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output tcba_pkg::dp_cmd_t cmd
);

  import tcba_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;
  logic   accept;

  assign slot_free = !rsp_valid || rsp_ready;
  assign req_ready = (state == ST_IDLE) || (state == ST_FINISH && slot_free);
  assign accept    = req_valid && req_ready;

  assign cmd.capture = accept;
  assign cmd.decide  = (state == ST_DECODE);
  assign cmd.load    = (state == ST_FINISH) && slot_free;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (slot_free) begin
          state_next = accept ? ST_DECODE : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_accept_to_decode: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_DECODE) else $error("accepted request not decoded");
  a_decode_to_finish: assert property (@(posedge clk) disable iff (rst)
    state == ST_DECODE |=> state == ST_FINISH) else $error("decode not followed by finish");
  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> rsp_valid) else $error("loaded result not presented");
  a_no_load_on_stall: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |-> !cmd.load) else $error("result overwritten while stalled");
`endif

endmodule
